### rtl/s2a_pkg.sv
// Shared types, mode codes and character tables for the scancode decoder.
`timescale 1ns / 1ps

package s2a_pkg;

    // Decode mode codes
    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_ASCII   = 2'd1;
    localparam logic [1:0] MODE_UNICODE = 2'd2;
    localparam logic [1:0] MODE_RESET   = MODE_ASCII;

    // Scancodes with special meaning
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3a;
    localparam logic [7:0] SC_PREFIX_BASE  = 8'he0;

    // Modifier and prefix state
    typedef struct packed {
        logic shift_held;
        logic caps_on;
        logic prefix_pending;
    } s2a_state_t;

    // Result of decoding one byte
    typedef struct packed {
        logic       emit;
        logic [7:0] char_code;
        s2a_state_t state_next;
    } s2a_result_t;

    // Unshifted AZERTY map
    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:    ch = 8'h1b;
            7'd2:    ch = 8'h26;
            7'd3:    ch = 8'h65;
            7'd4:    ch = 8'h22;
            7'd5:    ch = 8'h27;
            7'd6:    ch = 8'h28;
            7'd7:    ch = 8'h2d;
            7'd8:    ch = 8'h65;
            7'd9:    ch = 8'h5f;
            7'd10:   ch = 8'h63;
            7'd11:   ch = 8'h61;
            7'd12:   ch = 8'h29;
            7'd13:   ch = 8'h3d;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h61;
            7'd17:   ch = 8'h7a;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6f;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5e;
            7'd27:   ch = 8'h24;
            7'd28:   ch = 8'h0a;
            7'd30:   ch = 8'h71;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6a;
            7'd37:   ch = 8'h6b;
            7'd38:   ch = 8'h6c;
            7'd39:   ch = 8'h6d;
            7'd40:   ch = 8'h75;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h5c;
            7'd44:   ch = 8'h77;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6e;
            7'd50:   ch = 8'h2c;
            7'd51:   ch = 8'h3b;
            7'd52:   ch = 8'h3a;
            7'd53:   ch = 8'h21;
            7'd55:   ch = 8'h2a;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted AZERTY map
    function automatic logic [7:0] upper_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:    ch = 8'h1b;
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h6f;
            7'd13:   ch = 8'h2b;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h41;
            7'd17:   ch = 8'h5a;
            7'd18:   ch = 8'h45;
            7'd19:   ch = 8'h52;
            7'd20:   ch = 8'h54;
            7'd21:   ch = 8'h59;
            7'd22:   ch = 8'h55;
            7'd23:   ch = 8'h49;
            7'd24:   ch = 8'h4f;
            7'd25:   ch = 8'h50;
            7'd26:   ch = 8'h22;
            7'd28:   ch = 8'h0d;
            7'd30:   ch = 8'h51;
            7'd31:   ch = 8'h53;
            7'd32:   ch = 8'h44;
            7'd33:   ch = 8'h46;
            7'd34:   ch = 8'h47;
            7'd35:   ch = 8'h48;
            7'd36:   ch = 8'h4a;
            7'd37:   ch = 8'h4b;
            7'd38:   ch = 8'h4c;
            7'd39:   ch = 8'h4d;
            7'd40:   ch = 8'h25;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h5c;
            7'd44:   ch = 8'h57;
            7'd45:   ch = 8'h58;
            7'd46:   ch = 8'h43;
            7'd47:   ch = 8'h56;
            7'd48:   ch = 8'h42;
            7'd49:   ch = 8'h4e;
            7'd50:   ch = 8'h3f;
            7'd51:   ch = 8'h2e;
            7'd52:   ch = 8'h2f;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/s2a_decode.sv
// Combinational decode of one scancode byte against the modifier state.
`timescale 1ns / 1ps

module s2a_decode (
    input  logic [1:0]          mode,
    input  logic [7:0]          scan_byte,
    input  s2a_pkg::s2a_state_t state_cur,
    output s2a_pkg::s2a_result_t result
);
    import s2a_pkg::*;

    s2a_state_t st;
    logic       upper_sel;

    // Raw: byte through; ASCII: modifiers, prefix handling and table lookup
    always_comb
    begin
        st        = state_cur;
        upper_sel = 1'b0;
        result    = '0;
        case (mode)
            MODE_RAW:
            begin
                result.emit      = 1'b1;
                result.char_code = scan_byte;
            end
            MODE_ASCII:
            begin
                if (scan_byte == SC_LSHIFT_MAKE || scan_byte == SC_RSHIFT_MAKE)
                    st.shift_held = 1'b1;
                else if (scan_byte == SC_LSHIFT_BREAK || scan_byte == SC_RSHIFT_BREAK)
                    st.shift_held = 1'b0;
                else if (scan_byte == SC_CAPS_MAKE)
                    st.caps_on = ~st.caps_on;

                upper_sel = st.shift_held ^ st.caps_on;
                if (scan_byte > SC_PREFIX_BASE)
                begin
                    st.prefix_pending = 1'b1;
                end
                else if (st.prefix_pending)
                begin
                    // byte after a prefix is swallowed
                    st.prefix_pending = 1'b0;
                end
                else if (!scan_byte[7])
                begin
                    result.emit      = 1'b1;
                    result.char_code = upper_sel ? upper_char(scan_byte[6:0])
                                                 : plain_char(scan_byte[6:0]);
                end
            end
            default:
            begin
                // unicode and unused code: no output, state kept
            end
        endcase
        result.state_next = st;
    end

endmodule

### rtl/scancode_to_ascii_decoder.sv
// Top level: set-1 scancode to AZERTY character decoder with stream ports.
// Results are registered and show in the cycle after the input transfer.
// Throughput: one byte per cycle; the single result register frees in the
// cycle its transfer completes, so input is taken whenever m_tready is high.
// Reset (rst_n low, async): mode returns to ASCII, shift/caps/prefix clear,
// result register empties.
`timescale 1ns / 1ps

module scancode_to_ascii_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_wdata,   // decode_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] scan_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [7:0] char_code
);
    import s2a_pkg::*;

    logic [1:0]  mode_reg;
    s2a_state_t  state_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    s2a_result_t dec;
    logic        s_xfer;

    s2a_decode u_decode (
        .mode      (mode_reg),
        .scan_byte (s_tdata),
        .state_cur (state_reg),
        .result    (dec)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Mode register, modifier state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                mode_reg <= cfg_wdata;
            if (s_xfer)
            begin
                state_reg     <= dec.state_next;
                out_valid_reg <= dec.emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s_xfer && dec.emit)
            out_data_reg <= dec.char_code;
    end

endmodule

### rtl/s2a_checker.sv
// Port-level checker for the scancode decoder, bound to the top level.
`timescale 1ns / 1ps

module s2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wen,
    input logic [1:0] cfg_wdata,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import s2a_pkg::*;

    logic [1:0] mode_reg;
    logic       s_xfer;
    logic       out_free;

    // Shadow copy of the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_wen)
            mode_reg <= cfg_wdata;
    end

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // Result register is empty while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is never blocked when the result side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_free |-> s_tready)
        else $error("s_tready low with free result register");

    // Raw mode passes the byte through in the next cycle
    a_raw: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && mode_reg == MODE_RAW && !cfg_wen |=> m_tvalid && m_tdata == $past(s_tdata))
        else $error("raw byte not passed through");

    // High bytes in ASCII mode and all bytes in unicode mode give no result
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && out_free &&
        ((mode_reg == MODE_ASCII && s_tdata[7]) || mode_reg == MODE_UNICODE)
        |=> !m_tvalid)
        else $error("unexpected result");

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

### tb/sv/scancode_to_ascii_decoder_test.sv
// Stream testbench for the set-1 scancode to AZERTY character decoder.
`timescale 1ns / 1ps

module scancode_to_ascii_decoder_test;

    import s2a_pkg::*;

    // Mode code 3 has no meaning and must behave like unicode mode
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         RUN_LIMIT  = 300000;
    localparam int         MAP_SIZE   = 56;

    // Character maps, entry 0 in the top byte; codes 56..127 map to zero
    localparam logic [MAP_SIZE*8-1:0] PLAIN_ROW = {
        8'h00, 8'h1b, 8'h26, 8'h65, 8'h22, 8'h27, 8'h28, 8'h2d,
        8'h65, 8'h5f, 8'h63, 8'h61, 8'h29, 8'h3d, 8'h08, 8'h09,
        8'h61, 8'h7a, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h5e, 8'h24, 8'h0a, 8'h00, 8'h71, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h6d,
        8'h75, 8'h60, 8'h00, 8'h5c, 8'h77, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h2c, 8'h3b, 8'h3a, 8'h21, 8'h00, 8'h2a
    };
    localparam logic [MAP_SIZE*8-1:0] UPPER_ROW = {
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h6f, 8'h2b, 8'h08, 8'h09,
        8'h41, 8'h5a, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h22, 8'h00, 8'h0d, 8'h00, 8'h51, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h4d,
        8'h25, 8'h60, 8'h00, 8'h5c, 8'h57, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h3f, 8'h2e, 8'h2f, 8'h00, 8'h00, 8'h00
    };

    // Directed opening sequence in ASCII mode, first byte in the top byte:
    // plain key, table extremes, release, prefix swallow, shift and caps
    // combinations, 0xE0 as a non-prefix, prefix while pending, shift made
    // inside a swallowed byte, enter and an unmapped key
    localparam int DIRECTED_LEN = 26;
    localparam logic [DIRECTED_LEN*8-1:0] DIRECTED_SEQ = {
        8'h10, 8'h00, 8'h7f, 8'h80, 8'hff, 8'h10, 8'h2a, 8'h10,
        8'haa, 8'h3a, 8'h10, 8'h36, 8'h10, 8'hb6, 8'h3a, 8'he0,
        8'h10, 8'he1, 8'he1, 8'h10, 8'he5, 8'h2a, 8'h10, 8'haa,
        8'h1c, 8'h38
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b1;
    logic       cfg_wen   = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;

    // Scancodes waiting to be sent, characters waiting to arrive
    logic [7:0] key_q[$];
    logic [7:0] char_q[$];

    // Predicted decoder state
    logic [1:0] cur_mode     = MODE_ASCII;
    logic       shift_down   = 1'b0;
    logic       caps_lock    = 1'b0;
    logic       swallow_next = 1'b0;

    // Traffic shaping, set per phase
    int   gap_max  = 4;
    logic stall_on = 1'b1;

    int   burst_left = 0;
    int   gap_left   = 0;
    logic [15:0] ready_pattern = 16'hffff;
    logic [3:0]  pattern_pos   = 4'd0;
    int   mismatches  = 0;
    int   cycles      = 0;

    scancode_to_ascii_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] scan_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [7:0] char_code
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] map_char(input logic [MAP_SIZE*8-1:0] row,
                                            input logic [6:0] code);
        if (code >= MAP_SIZE)
            return 8'h00;
        return row[(MAP_SIZE - 1 - code) * 8 +: 8];
    endfunction

    // Advance the decoder state by one scancode and queue any character
    task automatic decode_scancode(input logic [7:0] code);
        logic upper;
        if (cur_mode == MODE_RAW)
        begin
            char_q.push_back(code);
        end
        else if (cur_mode == MODE_ASCII)
        begin
            // modifiers track on every byte, swallowed ones included
            if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE)
                shift_down = 1'b1;
            else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK)
                shift_down = 1'b0;
            else if (code == SC_CAPS_MAKE)
                caps_lock = ~caps_lock;

            if (code > SC_PREFIX_BASE)
                swallow_next = 1'b1;
            else if (swallow_next)
                swallow_next = 1'b0;
            else if (!code[7])
            begin
                upper = shift_down ^ caps_lock;
                char_q.push_back(upper ? map_char(UPPER_ROW, code[6:0])
                                       : map_char(PLAIN_ROW, code[6:0]));
            end
        end
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                decode_scancode(s_tdata);
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (key_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= key_q.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 15);
                    gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a 16-bit pattern redrawn each lap, or stays high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= stall_on ? ready_pattern[pattern_pos] : 1'b1;
            if (pattern_pos == 4'd15)
            begin
                pattern_pos <= 4'd0;
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= 16'($urandom & $urandom);
                    1:       ready_pattern <= 16'hffff;
                    default: ready_pattern <= 16'($urandom | $urandom);
                endcase
            end
            else
            begin
                pattern_pos <= pattern_pos + 4'd1;
            end
        end
    end

    // Check each character transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (char_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected character %02h", m_tdata);
                mismatches <= mismatches + 1;
            end
            else if (char_q[0] !== m_tdata)
            begin
                if (mismatches < 10)
                    $display("char_code mismatch: expected %02h got %02h",
                             char_q[0], m_tdata);
                mismatches <= mismatches + 1;
                void'(char_q.pop_front());
            end
            else
            begin
                void'(char_q.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("scancode_to_ascii_decoder_test failed");
            $finish;
        end
    end

    // Wait until every scancode is sent and every character has arrived
    task automatic wait_quiet();
        while (key_q.size() > 0 || s_tvalid || char_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic add_noise(input int count);
        for (int i = 0; i < count; i++)
            key_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Keyboard-like traffic: keystrokes with releases, shifted runs, caps
    // toggles, prefixed pairs, plus some 0xE0 pairs and raw noise
    task automatic add_typing(input int count);
        int sent;
        int pick;
        logic [7:0] code;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                code = 8'($urandom_range(1, 8'h39));
                key_q.push_back(code);
                sent++;
                if ($urandom_range(0, 9) < 4)
                begin
                    key_q.push_back(code | 8'h80);
                    sent++;
                end
            end
            else if (pick < 65)
            begin
                key_q.push_back($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
                repeat ($urandom_range(1, 4))
                begin
                    key_q.push_back(8'($urandom_range(0, 8'h7f)));
                    sent++;
                end
                key_q.push_back($urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
                sent += 2;
            end
            else if (pick < 72)
            begin
                key_q.push_back(SC_CAPS_MAKE);
                key_q.push_back(SC_CAPS_MAKE | 8'h80);
                sent += 2;
            end
            else if (pick < 82)
            begin
                key_q.push_back(8'($urandom_range(SC_PREFIX_BASE + 1, 8'hff)));
                key_q.push_back(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else if (pick < 90)
            begin
                key_q.push_back(SC_PREFIX_BASE);
                key_q.push_back(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else
            begin
                key_q.push_back(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        // Drive reset low as a real falling edge so the async reset fires
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases in the reset mode
        for (int i = 0; i < DIRECTED_LEN; i++)
            key_q.push_back(DIRECTED_SEQ[(DIRECTED_LEN - 1 - i) * 8 +: 8]);
        wait_quiet();

        // Raw passthrough, extremes first
        write_mode(MODE_RAW);
        key_q.push_back(8'h00);
        key_q.push_back(8'hff);
        add_noise(60);
        wait_quiet();

        // Silent modes, prefixes and modifiers included
        write_mode(MODE_UNICODE);
        add_typing(20);
        wait_quiet();
        write_mode(MODE_SPARE);
        add_noise(20);
        wait_quiet();

        // Main ASCII traffic with idling on both sides
        write_mode(MODE_ASCII);
        gap_max = 8;
        add_typing(200);
        wait_quiet();

        write_mode(MODE_RAW);
        gap_max = 2;
        add_noise(40);
        wait_quiet();

        // Back-to-back traffic with no idling
        write_mode(MODE_ASCII);
        gap_max  = 0;
        stall_on = 1'b0;
        add_typing(100);
        wait_quiet();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && char_q.size() == 0)
            $display("scancode_to_ascii_decoder_test passed");
        else
            $display("scancode_to_ascii_decoder_test failed");
        $finish;
    end

endmodule
